FILE: hw/rtl/lec_pkg.sv
`timescale 1ns / 1ps

package lec_pkg;

	localparam int CFG_W = 13;
	localparam int POS_W = 13;
	localparam int VAL_W = 32;
	localparam int CNT_W = 12;
	localparam int APB_AW = 2;
	localparam int APB_DW = 32;

	localparam logic [APB_AW-1:0] REG_ARRAY_LENGTH = 2'd0;

	typedef struct packed {
		logic                    action;
		logic [POS_W-1:0]        position;
		logic signed [VAL_W-1:0] new_value;
	} item_t;

	typedef struct packed {
		logic [CNT_W-1:0] extrema_count;
		logic             position_error;
	} result_t;

endpackage

FILE: hw/rtl/local_extrema_counter.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake                 Payload
// item      in   item_valid / item_stall   lec_pkg::item_t   (action, position, new_value)
// result    out  result_valid/result_stall lec_pkg::result_t (extrema_count, position_error)
// apb       in   psel/penable/pready       array_length at byte address 0
//
// From acceptance to the next acceptance a valid request runs five reads of positions
// p-2..p+2 through the single sample memory read port, a drain state for the read latency,
// and a finish state that waits for out_free, writes the value back and loads result_q.
// A position error goes straight to the finish state and touches no memory.
// After reset the sample memory is cleared one entry per cycle, all MAX_LENGTH entries, with
// item_stall high. The next request can do its reads while a result is stalled.

module local_extrema_counter #(
	parameter int MAX_LENGTH = 4096
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     item_valid,
	output logic                     item_stall,
	input  lec_pkg::item_t           item,
	output logic                     result_valid,
	input  logic                     result_stall,
	output lec_pkg::result_t         result,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [lec_pkg::APB_AW-1:0] paddr,
	input  logic [lec_pkg::APB_DW-1:0] pwdata,
	output logic [lec_pkg::APB_DW-1:0] prdata,
	output logic                     pready
);
	import lec_pkg::*;

	localparam int AW = $clog2(MAX_LENGTH);
	localparam int LW = ($clog2(MAX_LENGTH + 1) > CFG_W) ? $clog2(MAX_LENGTH + 1) : CFG_W;
	localparam int CW = LW + 1;
	localparam logic [2:0] LAST_RD = 3'd4;

	typedef enum logic [4:0] {
		ST_CLEAR  = 5'b00001,
		ST_IDLE   = 5'b00010,
		ST_READ   = 5'b00100,
		ST_DRAIN  = 5'b01000,
		ST_FINISH = 5'b10000
	} state_t;

	state_t state_q;

	logic [LW-1:0]           len_q;
	logic [LW-1:0]           len_eff;
	logic [CNT_W-1:0]        total_q;
	logic [CNT_W-1:0]        acc_q;
	item_t                   req_q;
	logic                    err_q;
	logic [2:0]              rd_idx_q;
	logic [AW-1:0]           clr_q;
	logic                    rd_vld_s1;
	logic [2:0]              rd_idx_s1;
	logic signed [VAL_W-1:0] win0_q;
	logic signed [VAL_W-1:0] win1_q;
	logic signed [VAL_W-1:0] rdata_s1;
	logic                    result_valid_q;
	result_t                 result_q;

	logic [VAL_W-1:0]        mem [MAX_LENGTH];
	logic                    mem_we;
	logic [AW-1:0]           mem_wa;
	logic [VAL_W-1:0]        mem_wd;
	logic [AW-1:0]           mem_ra;

	logic                    item_acc;
	logic                    out_free;
	logic                    cfg_wr;
	logic [CW-1:0]           rd_pos;
	logic                    rd_in_range;
	logic [CW-1:0]           win_pos;
	logic                    win_use;
	logic signed [VAL_W-1:0] l_new;
	logic signed [VAL_W-1:0] m_new;
	logic signed [VAL_W-1:0] r_new;
	logic                    ext_old;
	logic                    ext_new;
	logic                    p_bad;

	function automatic logic is_ext(input logic signed [VAL_W-1:0] l,
	                                input logic signed [VAL_W-1:0] m,
	                                input logic signed [VAL_W-1:0] r);
		return ((m < l) && (m < r)) || ((m > l) && (m > r));
	endfunction

	assign pready = 1'b1;
	assign prdata = APB_DW'(len_q);
	assign cfg_wr = psel && penable && pwrite && (paddr == REG_ARRAY_LENGTH);

	always_comb begin
		if (len_q > LW'(MAX_LENGTH)) begin
			len_eff = LW'(MAX_LENGTH);
		end else begin
			len_eff = len_q;
		end
	end

	assign item_stall   = (state_q != ST_IDLE);
	assign item_acc     = item_valid && !item_stall;
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign out_free     = !result_valid_q || !result_stall;

	assign p_bad = (item.position == '0) || (CW'(item.position) > CW'(len_eff));

	// positions p-2..p+2 are read in order; rd_pos is position + 2
	assign rd_pos      = CW'(req_q.position) + CW'(rd_idx_q);
	assign rd_in_range = (rd_pos >= CW'(3)) && (rd_pos <= CW'(len_eff) + CW'(2));

	// window centered on p-3+idx, evaluated when its right sample arrives
	assign win_pos = CW'(req_q.position) + CW'(rd_idx_s1);
	assign win_use = rd_vld_s1 && (rd_idx_s1 >= 3'd2) && (win_pos >= CW'(5))
	                 && (win_pos <= CW'(len_eff) + CW'(2));

	always_comb begin
		l_new = (rd_idx_s1 == 3'd4) ? req_q.new_value : win0_q;
		m_new = (rd_idx_s1 == 3'd3) ? req_q.new_value : win1_q;
		r_new = (rd_idx_s1 == 3'd2) ? req_q.new_value : rdata_s1;
		ext_old = is_ext(win0_q, win1_q, rdata_s1);
		ext_new = is_ext(l_new, m_new, r_new);
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = clr_q;
		mem_wd = '0;
		mem_ra = '0;
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
			end
			ST_READ: begin
				if (rd_in_range) begin
					mem_ra = AW'(rd_pos - CW'(3));
				end
			end
			ST_FINISH: begin
				mem_we = out_free && req_q.action && !err_q;
				mem_wa = AW'(CW'(req_q.position) - CW'(1));
				mem_wd = req_q.new_value;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rdata_s1 <= mem[mem_ra];
	end

	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			win0_q <= win1_q;
			win1_q <= rdata_s1;
		end
		if (item_acc) begin
			req_q <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			len_q          <= LW'(MAX_LENGTH);
			total_q        <= '0;
			acc_q          <= '0;
			err_q          <= 1'b0;
			rd_idx_q       <= '0;
			clr_q          <= '0;
			rd_vld_s1      <= 1'b0;
			rd_idx_s1      <= '0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			if (cfg_wr) begin
				len_q <= LW'(pwdata[CFG_W-1:0]);
			end
			if ((state_q == ST_FINISH) && out_free) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			rd_vld_s1 <= (state_q == ST_READ);
			if (win_use) begin
				acc_q <= acc_q + CNT_W'(ext_new) - CNT_W'(ext_old);
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(MAX_LENGTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (item_acc) begin
						acc_q    <= total_q;
						err_q    <= p_bad;
						rd_idx_q <= '0;
						state_q  <= p_bad ? ST_FINISH : ST_READ;
					end
				end
				ST_READ: begin
					rd_idx_s1 <= rd_idx_q;
					rd_idx_q  <= rd_idx_q + 3'd1;
					if (rd_idx_q == LAST_RD) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_free) begin
						result_q.extrema_count  <= acc_q;
						result_q.position_error <= err_q;
						if (req_q.action && !err_q) begin
							total_q <= acc_q;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: bench/local_extrema_counter_test.sv
`timescale 1ns / 1ps

module local_extrema_counter_test;
	import lec_pkg::*;

	localparam int MAX_LEN = 4096;
	localparam logic QUERY = 1'b0;
	localparam logic APPLY = 1'b1;

	typedef struct packed {
		logic             cfg;
		logic [CFG_W-1:0] length;
		item_t            it;
		logic             typed;
		result_t          want;
	} row_t;

	localparam int PLAN_N = 25;
	localparam row_t PLAN [PLAN_N] = '{
		'{1'b0, 13'd0, '{QUERY, 13'd0, 32'sd0}, 1'b1, '{12'd0, 1'b1}},
		'{1'b0, 13'd0, '{APPLY, 13'd8191, -32'sd1}, 1'b1, '{12'd0, 1'b1}},
		'{1'b0, 13'd0, '{APPLY, 13'd4097, 32'sd5}, 1'b1, '{12'd0, 1'b1}},
		'{1'b0, 13'd0, '{QUERY, 13'd1, 32'sh7fffffff}, 1'b1, '{12'd0, 1'b0}},
		'{1'b0, 13'd0, '{APPLY, 13'd4096, 32'sh7fffffff}, 1'b0, '{12'd0, 1'b0}},
		'{1'b0, 13'd0, '{APPLY, 13'd2, 32'sh80000000}, 1'b0, '{12'd0, 1'b0}},
		'{1'b0, 13'd0, '{APPLY, 13'd4, 32'sd5}, 1'b0, '{12'd0, 1'b0}},
		'{1'b0, 13'd0, '{QUERY, 13'd3, 32'sd7}, 1'b0, '{12'd0, 1'b0}},
		'{1'b0, 13'd0, '{APPLY, 13'd3, 32'sh7fffffff}, 1'b0, '{12'd0, 1'b0}},
		'{1'b0, 13'd0, '{APPLY, 13'd4095, 32'sh7fffffff}, 1'b0, '{12'd0, 1'b0}},
		'{1'b0, 13'd0, '{QUERY, 13'd4096, 32'sd0}, 1'b0, '{12'd0, 1'b0}},
		'{1'b0, 13'd0, '{APPLY, 13'd1, 32'sh80000000}, 1'b0, '{12'd0, 1'b0}},
		'{1'b1, 13'd0, '{QUERY, 13'd0, 32'sd0}, 1'b0, '{12'd0, 1'b0}},
		'{1'b0, 13'd0, '{APPLY, 13'd1, 32'sd7}, 1'b0, '{12'd0, 1'b0}},
		'{1'b1, 13'd8191, '{QUERY, 13'd0, 32'sd0}, 1'b0, '{12'd0, 1'b0}},
		'{1'b0, 13'd0, '{APPLY, 13'd4096, -32'sd5}, 1'b0, '{12'd0, 1'b0}},
		'{1'b1, 13'd2, '{QUERY, 13'd0, 32'sd0}, 1'b0, '{12'd0, 1'b0}},
		'{1'b0, 13'd0, '{APPLY, 13'd2, 32'sd9}, 1'b0, '{12'd0, 1'b0}},
		'{1'b0, 13'd0, '{QUERY, 13'd3, 32'sd0}, 1'b0, '{12'd0, 1'b0}},
		'{1'b1, 13'd1, '{QUERY, 13'd0, 32'sd0}, 1'b0, '{12'd0, 1'b0}},
		'{1'b0, 13'd0, '{APPLY, 13'd1, -32'sd9}, 1'b0, '{12'd0, 1'b0}},
		'{1'b1, 13'd3, '{QUERY, 13'd0, 32'sd0}, 1'b0, '{12'd0, 1'b0}},
		'{1'b0, 13'd0, '{APPLY, 13'd2, 32'sd100}, 1'b0, '{12'd0, 1'b0}},
		'{1'b1, 13'd4096, '{QUERY, 13'd0, 32'sd0}, 1'b0, '{12'd0, 1'b0}},
		'{1'b0, 13'd0, '{QUERY, 13'd3, -32'sd100}, 1'b0, '{12'd0, 1'b0}}
	};

	localparam int PHASES = 14;
	localparam int PHASE_LEN [PHASES] = '{5, 16, 3, 4096, 64, 8191, 2, 0, 1, 9, 4096, 33, 4, 200};

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                item_valid = 1'b0;
	logic                item_stall;
	item_t               item = '0;
	logic                result_valid;
	logic                result_stall = 1'b0;
	result_t             result;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [APB_AW-1:0]   paddr = '0;
	logic [APB_DW-1:0]   pwdata = '0;
	logic [APB_DW-1:0]   prdata;
	logic                pready;

	local_extrema_counter dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	always #1 clk = ~clk;

	// mirror of the block state
	logic signed [VAL_W-1:0] samples [MAX_LEN];
	logic [CNT_W-1:0]        extrema_now;
	logic [CFG_W-1:0]        length_reg;

	result_t pending_q [$];
	int      mismatches = 0;
	int      requests_sent = 0;
	int      results_seen = 0;
	int      errors_seen = 0;
	int      settings_used = 0;
	int      burst_left = 0;

	function automatic int unsigned active_length();
		return (length_reg > MAX_LEN) ? MAX_LEN : length_reg;
	endfunction

	function automatic logic signed [VAL_W-1:0] value_at(int unsigned k, int unsigned p,
			logic signed [VAL_W-1:0] v, bit sub);
		if (sub && k == p)
			return v;
		return samples[(k - 1) % MAX_LEN];
	endfunction

	function automatic bit is_peak(logic signed [VAL_W-1:0] l, logic signed [VAL_W-1:0] m,
			logic signed [VAL_W-1:0] r);
		return (m < l && m < r) || (m > l && m > r);
	endfunction

	// count with the proposed value in place; commits on apply
	function automatic result_t predict_extrema(item_t it);
		int unsigned len;
		int unsigned p;
		int unsigned c;
		logic [CNT_W-1:0] tot;
		result_t r;
		len = active_length();
		p = it.position;
		tot = extrema_now;
		r.extrema_count = extrema_now;
		r.position_error = 1'b1;
		if (p < 1 || p > len)
			return r;
		for (c = (p > 1) ? p - 1 : 1; c <= p + 1; c++) begin
			if (c < 2 || c + 1 > len)
				continue;
			tot = tot - CNT_W'(is_peak(value_at(c - 1, p, it.new_value, 0),
				value_at(c, p, it.new_value, 0), value_at(c + 1, p, it.new_value, 0)));
			tot = tot + CNT_W'(is_peak(value_at(c - 1, p, it.new_value, 1),
				value_at(c, p, it.new_value, 1), value_at(c + 1, p, it.new_value, 1)));
		end
		r.extrema_count = tot;
		r.position_error = 1'b0;
		if (it.action == APPLY) begin
			extrema_now = tot;
			samples[(p - 1) % MAX_LEN] = it.new_value;
		end
		return r;
	endfunction

	task automatic flag(string what, int unsigned got, int unsigned want);
		$display("%0t mismatch: %s got %0d want %0d", $time, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin
		result_t w;
		if (arst_n && result_valid && !result_stall) begin
			results_seen++;
			if (pending_q.size() == 0) begin
				flag("result with nothing pending", result, 0);
			end else begin
				w = pending_q.pop_front();
				if (result.extrema_count !== w.extrema_count)
					flag("extrema_count", result.extrema_count, w.extrema_count);
				if (result.position_error !== w.position_error)
					flag("position_error", result.position_error, w.position_error);
				if (w.position_error)
					errors_seen++;
			end
		end
	end

	int stall_cyc = 0;
	int stall_mode = 0;
	always @(negedge clk) begin
		stall_cyc++;
		if (stall_cyc % 300 == 0)
			stall_mode = $urandom_range(0, 3);
		case (stall_mode)
			0: result_stall <= 1'b0;
			1: result_stall <= ($urandom_range(0, 1) == 1);
			2: result_stall <= (stall_cyc % 13) < 6;
			default: result_stall <= ($urandom_range(0, 9) == 0);
		endcase
	end

	task automatic send(item_t it, bit typed, result_t want);
		result_t p;
		@(negedge clk);
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (item_stall);
		p = predict_extrema(it);
		pending_q.push_back(typed ? want : p);
		requests_sent++;
		if (burst_left == 0) begin
			@(negedge clk);
			item_valid <= 1'b0;
			repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 4))
				@(negedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
		end else begin
			burst_left--;
		end
	endtask

	task automatic drain();
		@(negedge clk);
		item_valid <= 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_length(logic [CFG_W-1:0] n);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_ARRAY_LENGTH;
		pwdata <= APB_DW'(n);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		length_reg = n;
		settings_used++;
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[CFG_W-1:0] !== n)
			flag("array_length readback", prdata[CFG_W-1:0], n);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic logic [POS_W-1:0] pick_position(int unsigned len);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (len == 0 || r < 4)
			return POS_W'($urandom_range(0, 8191));
		if (r < 8)
			return '0;
		if (r < 12)
			return POS_W'(len + 1);
		if (len > 40 && r < 50)
			return POS_W'($urandom_range(1, 20));
		if (len > 40 && r < 86)
			return POS_W'($urandom_range(len - 19, len));
		return POS_W'($urandom_range(1, len));
	endfunction

	function automatic logic signed [VAL_W-1:0] pick_value();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return $signed(VAL_W'($urandom_range(0, 6)) - VAL_W'(3));
		if (r < 75) begin
			case ($urandom_range(0, 3))
				0: return 32'sh7fffffff;
				1: return 32'sh80000000;
				2: return 32'sh7ffffffe;
				default: return 32'sh80000001;
			endcase
		end
		return $signed(VAL_W'($urandom()));
	endfunction

	initial begin
		#1_000_000;
		$display("[local_extrema_counter] ERROR");
		$finish;
	end

	initial begin
		item_t it;
		int n;
		for (int i = 0; i < MAX_LEN; i++)
			samples[i] = '0;
		extrema_now = '0;
		length_reg = CFG_W'(MAX_LEN);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < PLAN_N; i++) begin
			if (PLAN[i].cfg) begin
				drain();
				write_length(PLAN[i].length);
			end else begin
				send(PLAN[i].it, PLAN[i].typed, PLAN[i].want);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			write_length(CFG_W'(PHASE_LEN[ph]));
			n = (PHASE_LEN[ph] < 3) ? 40 : 150;
			for (int k = 0; k < n; k++) begin
				it.action = ($urandom_range(0, 99) < 70) ? APPLY : QUERY;
				it.position = pick_position(active_length());
				it.new_value = pick_value();
				send(it, 1'b0, '0);
			end
		end

		drain();
		$display("%0d requests over %0d length settings, %0d results checked",
			requests_sent, settings_used, results_seen);
		$display("%0d position errors seen, %0d mismatches", errors_seen, mismatches);
		if (mismatches == 0 && pending_q.size() == 0) begin
			$display("[local_extrema_counter] OK");
		end else begin
			$display("[local_extrema_counter] ERROR");
		end
		$finish;
	end

endmodule
